// ===== rtl/rtp_midi_command_parser_core_defines.svh =====
// assertion macros for the rtp-midi command parser
// used by the top level only, expects clk and rst_n in scope
`ifndef RTP_MIDI_COMMAND_PARSER_CORE_DEFINES_SVH
`define RTP_MIDI_COMMAND_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RTPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RTPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rtpm_pkg.sv =====
// shared types and constants of the rtp-midi command parser
// no dependencies
`default_nettype none

package rtpm_pkg;

  localparam int HEADER_BYTES_DEF = 12;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] RESET_BYTE  = 8'hFF;
  localparam logic [3:0] PROG_NIB    = 4'hC;
  localparam logic [3:0] CHPR_NIB    = 4'hD;
  localparam logic [7:0] MTC_QF      = 8'hF1;
  localparam logic [7:0] SONG_SEL    = 8'hF3;
  localparam logic [7:0] LEN_MASK    = 8'h0F;

  localparam logic KIND_MIDI = 1'b0;
  localparam logic KIND_SEQ  = 1'b1;

  // everything one packet byte produces: up to two midi bytes, then an optional report
  typedef struct packed {
    logic [1:0]  n_midi;
    logic [7:0]  midi0;
    logic [7:0]  midi1;
    logic        rpt;
    logic [15:0] seq;
  } bndl_t;

  // front to queue
  typedef struct packed {
    logic  push;
    bndl_t data;
  } push_t;

endpackage

`default_nettype wire

// ===== rtl/rtpm_if.sv =====
// valid/ready channel interfaces of the rtp-midi command parser
// no dependencies
`default_nettype none

interface rtpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       pkt_start;
  modport source (output valid, output pkt_byte, output pkt_start, input ready);
  modport sink   (input valid, input pkt_byte, input pkt_start, output ready);
endinterface

interface rtpm_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  midi_byte;
  logic [15:0] seq_number;
  logic        run_last;
  modport source (output valid, output out_kind, output midi_byte, output seq_number,
                  output run_last, input ready);
  modport sink   (input valid, input out_kind, input midi_byte, input seq_number,
                  input run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/rtpm_front.sv =====
// front end: accepts packet bytes, runs the header/length/list parser
// depends on rtpm_pkg and rtpm_in_if
`default_nettype none

module rtpm_front #(
  parameter int HEADER_BYTES = rtpm_pkg::HEADER_BYTES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  rtpm_in_if.sink             in_ch,
  input  wire logic           q_full,
  output rtpm_pkg::push_t     q_push
);
  import rtpm_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_LEN2, PH_LIST} phase_t;
  typedef enum logic [1:0] {SX_NONE, SX_RELAY, SX_DROP} sysex_t;

  localparam logic [3:0] HDR_LAST = 4'(HEADER_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic        long_form_r, long_form_nxt;
  logic [11:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  run_stat_r, run_stat_nxt;
  logic        in_delta_r, in_delta_nxt;
  sysex_t      sysex_r, sysex_nxt;
  logic        data_pend_r, data_pend_nxt;
  logic [15:0] seq_hold_r, seq_hold_nxt;
  bndl_t       bndl;
  logic        accept;

  function automatic bndl_t add_midi(bndl_t x, logic [7:0] v);
    bndl_t y;
    y = x;
    if (x.n_midi == 2'd0) y.midi0 = v;
    else y.midi1 = v;
    y.n_midi = x.n_midi + 2'd1;
    return y;
  endfunction

  function automatic logic one_data(logic [7:0] st);
    return (st[7:4] == PROG_NIB) || (st[7:4] == CHPR_NIB) || (st == MTC_QF) ||
           (st == SONG_SEL);
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    logic [7:0] b;
    b              = in_ch.pkt_byte;
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    long_form_nxt  = long_form_r;
    bytes_left_nxt = bytes_left_r;
    run_stat_nxt   = run_stat_r;
    in_delta_nxt   = in_delta_r;
    sysex_nxt      = sysex_r;
    data_pend_nxt  = data_pend_r;
    seq_hold_nxt   = seq_hold_r;
    bndl           = '0;

    // new packet drops whatever parse was in flight
    if (in_ch.pkt_start) begin
      phase_nxt      = PH_HEADER;
      hdr_cnt_nxt    = '0;
      long_form_nxt  = 1'b0;
      bytes_left_nxt = '0;
      run_stat_nxt   = '0;
      in_delta_nxt   = 1'b0;
      sysex_nxt      = SX_NONE;
      data_pend_nxt  = 1'b0;
    end

    case (phase_nxt)
      PH_HEADER: begin
        if (hdr_cnt_nxt < HDR_LAST) begin
          if (hdr_cnt_nxt == 4'd2) seq_hold_nxt[15:8] = b;
          if (hdr_cnt_nxt == 4'd3) seq_hold_nxt[7:0]  = b;
          hdr_cnt_nxt = hdr_cnt_nxt + 4'd1;
        end else begin
          long_form_nxt  = b[7];
          bytes_left_nxt = {4'd0, b[3:0]};
          if (b[7]) begin
            phase_nxt = PH_LEN2;
          end else if (b[3:0] == 4'd0) begin
            bndl.rpt  = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_LIST;
          end
        end
      end
      PH_LEN2: begin
        bytes_left_nxt = {bytes_left_nxt[3:0], b};
        if (bytes_left_nxt == 12'd0) begin
          bndl.rpt  = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_LIST;
        end
      end
      PH_LIST: begin
        if (data_pend_nxt) begin
          bndl          = add_midi(bndl, b);
          data_pend_nxt = 1'b0;
          in_delta_nxt  = 1'b1;
        end else if (sysex_nxt != SX_NONE) begin
          if (b == SYSEX_START || b == SYSEX_END) begin
            if (sysex_nxt == SX_RELAY) bndl = add_midi(bndl, SYSEX_END);
            sysex_nxt    = SX_NONE;
            in_delta_nxt = 1'b1;
          end else if (sysex_nxt == SX_RELAY) begin
            bndl = add_midi(bndl, b);
          end
        end else if (in_delta_nxt) begin
          if (!b[7]) in_delta_nxt = 1'b0;
        end else if (b == SYSEX_START) begin
          bndl      = add_midi(bndl, b);
          sysex_nxt = SX_RELAY;
        end else if (b == SYSEX_END) begin
          sysex_nxt = SX_DROP;
        end else if (b == RESET_BYTE) begin
          bndl         = add_midi(bndl, b);
          in_delta_nxt = 1'b1;
        end else if (b[7]) begin
          run_stat_nxt = b;
        end else begin
          bndl = add_midi(bndl, run_stat_nxt);
          bndl = add_midi(bndl, b);
          if (one_data(run_stat_nxt)) in_delta_nxt = 1'b1;
          else data_pend_nxt = 1'b1;
        end

        bytes_left_nxt = bytes_left_nxt - 12'd1;
        // list used up: close an open relay, then report
        if (bytes_left_nxt == 12'd0) begin
          if (sysex_nxt == SX_RELAY) bndl = add_midi(bndl, SYSEX_END);
          sysex_nxt     = SX_NONE;
          data_pend_nxt = 1'b0;
          bndl.rpt      = 1'b1;
          phase_nxt     = PH_IDLE;
        end
      end
      default: begin
      end
    endcase

    bndl.seq = bndl.rpt ? seq_hold_nxt : 16'd0;
  end

  assign q_push.push = accept && ((bndl.n_midi != 2'd0) || bndl.rpt);
  assign q_push.data = bndl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      hdr_cnt_r    <= '0;
      long_form_r  <= 1'b0;
      bytes_left_r <= '0;
      run_stat_r   <= '0;
      in_delta_r   <= 1'b0;
      sysex_r      <= SX_NONE;
      data_pend_r  <= 1'b0;
      seq_hold_r   <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      long_form_r  <= long_form_nxt;
      bytes_left_r <= bytes_left_nxt;
      run_stat_r   <= run_stat_nxt;
      in_delta_r   <= in_delta_nxt;
      sysex_r      <= sysex_nxt;
      data_pend_r  <= data_pend_nxt;
      seq_hold_r   <= seq_hold_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rtpm_queue.sv =====
// small register queue of result bundles between front and back
// depends on rtpm_pkg
`default_nettype none

module rtpm_queue #(
  parameter int DEPTH = rtpm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rtpm_pkg::push_t wr,
  input  wire logic            pop,
  output rtpm_pkg::bndl_t      head,
  output logic                 empty,
  output logic                 full
);
  import rtpm_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  bndl_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_FULL);
  assign head  = mem_r[rd_ptr_r];
  assign do_wr = wr.push && !full;
  assign do_rd = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    if (do_wr && !do_rd) cnt_nxt = cnt_r + CW'(1);
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr.data;
  end

endmodule

`default_nettype wire

// ===== rtl/rtpm_back.sv =====
// back end: walks one bundle a result at a time into the output register
// depends on rtpm_pkg and rtpm_out_if
`default_nettype none

module rtpm_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire rtpm_pkg::bndl_t head,
  input  wire logic            q_empty,
  output logic                 pop,
  rtpm_out_if.source           out_ch
);
  import rtpm_pkg::*;

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  midi_r, midi_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  total;
  logic        load;
  logic        is_last;

  assign total   = head.n_midi + {1'b0, head.rpt};
  assign is_last = (idx_r == 2'(total - 2'd1));
  assign load    = !q_empty && (!valid_r || out_ch.ready);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    midi_nxt  = midi_r;
    seq_nxt   = seq_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
      last_nxt  = is_last;
      if (idx_r < head.n_midi) begin
        kind_nxt = KIND_MIDI;
        midi_nxt = (idx_r == 2'd0) ? head.midi0 : head.midi1;
        seq_nxt  = '0;
      end else begin
        kind_nxt = KIND_SEQ;
        midi_nxt = '0;
        seq_nxt  = head.seq;
      end
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    midi_r <= midi_nxt;
    seq_r  <= seq_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.out_kind   = kind_r;
  assign out_ch.midi_byte  = midi_r;
  assign out_ch.seq_number = seq_r;
  assign out_ch.run_last   = last_r;

endmodule

`default_nettype wire

// ===== rtl/rtp_midi_command_parser_core.sv =====
// rtp-midi command section parser, top level
// depends on rtpm_pkg, rtpm_if, rtpm_front, rtpm_queue, rtpm_back and the defines header
//
// in_ch: one packet byte per transaction, pkt_start high on byte 0 of each packet.
//   header bytes 2 and 3 hold the sequence number; the byte after the header opens
//   the command section (short or long length form), then the midi list follows.
// out_ch: one result per transaction, out_kind 0 for a forwarded midi byte,
//   1 for the sequence number report when the section ends; run_last marks the
//   last result of one input byte. a byte may give no result, or up to three.
// path: an accepted byte is written into the queue, then the back end loads its
//   first result into the output register.
// throughput: one input byte per cycle while the queue has room; the back end
//   drains one result per cycle while the receiver is ready, so a byte with n results needs n output transactions.
//   the output register is the limit: at most one result leaves per clock.
// queue: QUEUE_DEPTH bundles sit between the parser and the output; in_ch.ready
//   drops only when it is full, so a stalled receiver backs up the queue first.
// reset: synchronous, active low; parser state, queue and output valid clear and
//   the block ignores bytes until it sees pkt_start.
`default_nettype none

`include "rtp_midi_command_parser_core_defines.svh"

module rtp_midi_command_parser_core #(
  parameter int HEADER_BYTES = rtpm_pkg::HEADER_BYTES_DEF,
  parameter int QUEUE_DEPTH  = rtpm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rtpm_in_if.sink     in_ch,
  rtpm_out_if.source  out_ch
);
  import rtpm_pkg::*;

  push_t q_push;   // parser output, one bundle per byte that yields anything
  bndl_t q_head;   // oldest bundle waiting for the back end
  logic  q_empty;
  logic  q_full;
  logic  q_pop;

  // front: parses every accepted byte in the cycle it arrives
  rtpm_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push)
  );

  // decoupling queue
  rtpm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  // back: serializes a bundle into single results
  rtpm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  // a report always closes the run of results of its byte
  `RTPM_ASSERT_NOW(a_rpt_is_last, out_ch.valid && out_ch.out_kind == KIND_SEQ, out_ch.run_last, "report not last")
  // the unused seq field of a midi result is zero
  `RTPM_ASSERT_NOW(a_midi_seq_zero, out_ch.valid && out_ch.out_kind == KIND_MIDI, out_ch.seq_number == 16'd0, "seq set on midi result")
  // the back end never pops an empty queue
  `RTPM_ASSERT_NOW(a_no_empty_pop, q_pop, !q_empty, "pop from empty queue")
  // a pop loads the last result of its bundle into the output register
  `RTPM_ASSERT_NEXT(a_pop_shows_last, q_pop, out_ch.valid && out_ch.run_last, "pop without last result")

endmodule

`default_nettype wire
